// File: hw/rtl/fre_pkg.sv
// Shared constants and types for the frame relative energy block.
package fre_pkg;

  localparam int MAX_FRAME        = 1024;
  localparam int FRAME_COUNT_BITS = 24;

  localparam int SAMPLE_W = 16;
  localparam int CHAN_W   = 4;
  localparam int POS_W    = 3;
  localparam int MEAN_W   = 31;
  localparam int CNT_W    = $clog2(MAX_FRAME + 1);
  // square of a magnitude is at most 2^30, so the frame sum stays below 2^(30+CNT_W)
  localparam int SUM_W    = 30 + CNT_W;
  localparam int TOT_W    = 56;
  localparam int PROD_W   = MEAN_W + FRAME_COUNT_BITS;
  // 100 fits in 7 bits
  localparam int DVD_W    = PROD_W + 7;
  localparam int DCNT_W   = $clog2(DVD_W + 1);

  localparam int ENERGY_SCALE = 100;
  localparam int DEFAULT_CHANNELS = 2;
  localparam int MAX_CHANNELS = 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_CHANNEL_COUNT = 1'b0;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [TOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/fre_div.sv
// Restoring divider, one quotient bit per cycle.
module fre_div (
  input  logic              clk,
  input  logic              rst_n,
  input  fre_pkg::div_req_t req,
  output fre_pkg::div_rsp_t rsp
);
  import fre_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DVD_W-1:0]   quo_r, quo_nxt;
  logic [TOT_W-1:0]   rem_r, rem_nxt;
  logic [TOT_W-1:0]   dsr_r, dsr_nxt;
  logic [TOT_W:0]     rem_sh;
  logic [TOT_W:0]     diff;

  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DVD_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      // borrow out means the shifted remainder is below the divisor
      if (!diff[TOT_W]) begin
        rem_nxt = diff[TOT_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[TOT_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: hw/rtl/frame_relative_energy.sv
// Short-time energy of channel 0 with energy relative to the running frame mean.
//
// Takes interleaved 16-bit words, squares and sums the channel 0 word of each
// group (channel count from register 0), and on a frame-end word returns the
// frame mean square and mean * frames * 100 / total energy. A word without
// frame end passes through the accumulate state before the next word is taken.
// A frame-end word runs up to two passes of the shared one-bit-per-cycle
// divider (mean, then ratio, with the total and product steps between them;
// a pass is skipped if its divisor is zero) and then waits only if the
// previous result has not yet been taken. The divider is the limiting unit.
module frame_relative_energy (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fre_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_frame_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [fre_pkg::MEAN_W-1:0]           out_mean_square,
  output logic [fre_pkg::MEAN_W-1:0]           out_relative_energy,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fre_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [fre_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [fre_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import fre_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_ACC    = 8'b0000_0010,
    ST_MSTART = 8'b0000_0100,
    ST_MWAIT  = 8'b0000_1000,
    ST_TOTAL  = 8'b0001_0000,
    ST_PROD   = 8'b0010_0000,
    ST_RSTART = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  localparam logic [FRAME_COUNT_BITS-1:0] FRAMES_MAX = '1;
  localparam logic [TOT_W-1:0]            TOTAL_MAX  = '1;
  localparam logic [MEAN_W-1:0]           OUT_MAX    = '1;

  state_t                      state_r, state_nxt;
  logic [CHAN_W-1:0]           chan_r, chan_nxt;
  logic [SAMPLE_W-1:0]         samp_r, samp_nxt;
  logic                        end_r, end_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [TOT_W-1:0]            total_r, total_nxt;
  logic [FRAME_COUNT_BITS-1:0] frames_r, frames_nxt;
  logic [MEAN_W-1:0]           mean_r, mean_nxt;
  logic [PROD_W-1:0]           prod_r, prod_nxt;
  logic [MEAN_W-1:0]           rel_r, rel_nxt;
  logic                        oval_r, oval_nxt;
  logic [MEAN_W-1:0]           omean_r, omean_nxt;
  logic [MEAN_W-1:0]           orel_r, orel_nxt;
  // marks that the running division is the ratio pass
  logic                        rel_pass_r, rel_pass_nxt;

  logic [SAMPLE_W:0]           ext;
  logic [SAMPLE_W:0]           mag;
  logic [2*SAMPLE_W+1:0]       sq;
  logic [CHAN_W-1:0]           eff;
  logic [CHAN_W-1:0]           pos_inc;
  logic [TOT_W:0]              tot_sum;
  logic                        cfg_wr;
  div_req_t                    dreq;
  div_rsp_t                    drsp;

  fre_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign ext     = {samp_r[SAMPLE_W-1], samp_r};
  assign mag     = samp_r[SAMPLE_W-1] ? (~ext + (SAMPLE_W+1)'(1)) : ext;
  assign sq      = mag * mag;
  assign eff     = (chan_r == '0) ? CHAN_W'(1) :
                   (chan_r > CHAN_W'(MAX_CHANNELS)) ? CHAN_W'(MAX_CHANNELS) : chan_r;
  assign pos_inc = {1'b0, pos_r} + CHAN_W'(1);
  assign tot_sum = {1'b0, total_r} + (TOT_W+1)'(mean_r);

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_CHANNEL_COUNT) ? CFG_DATA_W'(chan_r) : '0;

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = oval_r;
  assign out_mean_square     = omean_r;
  assign out_relative_energy = orel_r;

  always_comb begin
    state_nxt  = state_r;
    chan_nxt   = chan_r;
    samp_nxt   = samp_r;
    end_nxt    = end_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    frames_nxt = frames_r;
    mean_nxt   = mean_r;
    prod_nxt   = prod_r;
    rel_nxt    = rel_r;
    oval_nxt   = oval_r && out_stall;
    omean_nxt  = omean_r;
    orel_nxt   = orel_r;
    dreq.start    = 1'b0;
    dreq.dividend = DVD_W'(sum_r);
    dreq.divisor  = TOT_W'(cnt_r);

    if (cfg_wr && (paddr[2] == REG_CHANNEL_COUNT)) begin
      chan_nxt = pwdata[CHAN_W-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          samp_nxt  = in_sample;
          end_nxt   = in_frame_end;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if ((pos_r == '0) && (cnt_r < CNT_W'(MAX_FRAME))) begin
          sum_nxt = sum_r + SUM_W'(sq[MEAN_W-1:0]);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        pos_nxt   = (pos_inc >= eff) ? '0 : pos_inc[POS_W-1:0];
        state_nxt = end_r ? ST_MSTART : ST_IDLE;
      end
      ST_MSTART: begin
        if (cnt_r == '0) begin
          mean_nxt  = '0;
          state_nxt = ST_TOTAL;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = ST_MWAIT;
        end
      end
      ST_MWAIT: begin
        if (drsp.done) begin
          if (rel_pass_r) begin
            // ratio pass, saturated to the output width
            rel_nxt   = (|drsp.quotient[DVD_W-1:MEAN_W]) ? OUT_MAX
                                                         : drsp.quotient[MEAN_W-1:0];
            state_nxt = ST_FINISH;
          end else begin
            mean_nxt  = drsp.quotient[MEAN_W-1:0];
            state_nxt = ST_TOTAL;
          end
        end
      end
      ST_TOTAL: begin
        total_nxt = tot_sum[TOT_W] ? TOTAL_MAX : tot_sum[TOT_W-1:0];
        if (frames_r != FRAMES_MAX) begin
          frames_nxt = frames_r + FRAME_COUNT_BITS'(1);
        end
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        prod_nxt  = PROD_W'(mean_r) * PROD_W'(frames_r);
        state_nxt = ST_RSTART;
      end
      ST_RSTART: begin
        if (total_r == '0) begin
          rel_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = DVD_W'(prod_r) * DVD_W'(ENERGY_SCALE);
          dreq.divisor  = total_r;
          state_nxt     = ST_MWAIT;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!oval_r || !out_stall) begin
          oval_nxt  = 1'b1;
          omean_nxt = mean_r;
          orel_nxt  = rel_r;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          pos_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rel_pass_nxt = rel_pass_r;
    if (state_r == ST_MSTART) begin
      rel_pass_nxt = 1'b0;
    end else if ((state_r == ST_RSTART) && (total_r != '0)) begin
      rel_pass_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      chan_r     <= CHAN_W'(DEFAULT_CHANNELS);
      sum_r      <= '0;
      cnt_r      <= '0;
      pos_r      <= '0;
      total_r    <= '0;
      frames_r   <= '0;
      oval_r     <= 1'b0;
      rel_pass_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      chan_r     <= chan_nxt;
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
      total_r    <= total_nxt;
      frames_r   <= frames_nxt;
      oval_r     <= oval_nxt;
      rel_pass_r <= rel_pass_nxt;
    end
    samp_r  <= samp_nxt;
    end_r   <= end_nxt;
    mean_r  <= mean_nxt;
    prod_r  <= prod_nxt;
    rel_r   <= rel_nxt;
    omean_r <= omean_nxt;
    orel_r  <= orel_nxt;
  end

endmodule
